[rtl/tacc_pkg.sv]
package tacc_pkg;

  // register map
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CFG_SETTLE_WAIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFF_WAIT    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_TIME   = 2'd2;

  localparam logic [9:0] SettleWaitRst = 10'd250;
  localparam logic [9:0] OffWaitRst    = 10'd600;
  localparam logic [7:0] StepTimeRst   = 8'd6;

  // milliseconds in one configuration time unit
  localparam int MsPerUnit = 100;

  localparam int MoveW   = 23;
  localparam int SettleW = 17;

  // request types
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_TRIGGER = 3'd1;
  localparam logic [2:0] REQ_REPORT  = 3'd2;
  localparam logic [2:0] REQ_LIMIT   = 3'd3;
  localparam logic [2:0] REQ_BACKOFF = 3'd4;
  localparam logic [2:0] REQ_SELF    = 3'd5;

  // trigger actions
  localparam logic [1:0] ACT_INC = 2'd0;
  localparam logic [1:0] ACT_DEC = 2'd1;
  localparam logic [1:0] ACT_OFF = 2'd2;

  // stored pending action
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_INC  = 2'd1;
  localparam logic [1:0] PEND_DEC  = 2'd2;
  localparam logic [1:0] PEND_OFF  = 2'd3;

  // position report
  localparam logic [1:0] POS_HIGH = 2'd1;
  localparam logic [1:0] POS_LOW  = 2'd2;

  // limit event
  localparam logic [1:0] EVT_HIGH = 2'd0;
  localparam logic [1:0] EVT_LOW  = 2'd1;
  localparam logic [1:0] EVT_PREV = 2'd2;

  // operations
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_INC  = 3'd1;
  localparam logic [2:0] OP_DEC  = 3'd2;
  localparam logic [2:0] OP_OFF  = 3'd3;
  localparam logic [2:0] OP_BACK = 3'd4;

  // notices
  localparam logic [2:0] NOTE_NONE     = 3'd0;
  localparam logic [2:0] NOTE_MOVING   = 3'd1;
  localparam logic [2:0] NOTE_SWITCHING = 3'd2;
  localparam logic [2:0] NOTE_STOPPED  = 3'd3;
  localparam logic [2:0] NOTE_BACKING  = 3'd4;

  // command status
  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // completion codes
  localparam logic [1:0] CMP_NONE = 2'd0;
  localparam logic [1:0] CMP_INC  = 2'd1;
  localparam logic [1:0] CMP_DEC  = 2'd2;
  localparam logic [1:0] CMP_OFF  = 2'd3;

  // pin levels, bit 0 slow, bit 1 fast
  localparam logic [1:0] PINS_SLOW = 2'b01;
  localparam logic [1:0] PINS_FAST = 2'b10;
  localparam logic [1:0] PINS_HOLD = 2'b11;
  localparam logic [1:0] PINS_IDLE = 2'b00;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] action;
    logic [7:0] step_count;
    logic [1:0] position_code;
    logic [1:0] event_code;
    logic       self_flag;
  } item_t;

  typedef struct packed {
    logic       slow_pin;
    logic       fast_pin;
    logic [2:0] notice;
    logic       motor_active;
    logic [1:0] command_status;
    logic       query_request;
    logic [1:0] completion;
    logic [2:0] operation_now;
  } result_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic exec;  // apply the accepted item
    logic mul;   // form step product and settle threshold
    logic lim;   // scale step product to the move limit
    logic load;  // run stop and response checks, load the result
  } cmd_t;

endpackage

[rtl/tacc_if.sv]
interface tacc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [1:0] action;
  logic [7:0] step_count;
  logic [1:0] position_code;
  logic [1:0] event_code;
  logic       self_flag;

  modport source (output valid, req_type, action, step_count, position_code, event_code,
                  self_flag, input ready);
  modport sink (input valid, req_type, action, step_count, position_code, event_code,
                self_flag, output ready);
endinterface

interface tacc_out_if;
  logic       valid;
  logic       ready;
  logic       slow_pin;
  logic       fast_pin;
  logic [2:0] notice;
  logic       motor_active;
  logic [1:0] command_status;
  logic       query_request;
  logic [1:0] completion;
  logic [2:0] operation_now;

  modport source (output valid, slow_pin, fast_pin, notice, motor_active, command_status,
                  query_request, completion, operation_now, input ready);
  modport sink (input valid, slow_pin, fast_pin, notice, motor_active, command_status,
                query_request, completion, operation_now, output ready);
endinterface

interface tacc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_idx;
  logic [9:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

[rtl/tacc_ctrl.sv]
module tacc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tacc_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_LIM  = 4'b0100,
    S_CHK  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  assign cmd_o.exec = accept;
  assign cmd_o.mul  = (state_q == S_MUL);
  assign cmd_o.lim  = (state_q == S_LIM);
  assign cmd_o.load = (state_q == S_CHK) && slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_MUL;
      end
      S_MUL: state_d = S_LIM;
      S_LIM: state_d = S_CHK;
      S_CHK: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_MUL)
    else $error("accepted beat did not start the sequence");

  a_mul_to_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |=> state_q == S_LIM)
    else $error("limit stage skipped");

  a_result_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_CHK))
    else $error("result raised outside the check stage");
`endif

endmodule

[rtl/tacc_dp.sv]
module tacc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tacc_pkg::cmd_t                    cmd_i,
  input  tacc_pkg::item_t                   item_i,
  input  logic                              cfg_we_i,
  input  logic [tacc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tacc_pkg::CfgDataW-1:0]     cfg_data_i,
  output tacc_pkg::result_t                 res_o
);

  // configuration
  logic [9:0] settle_wait_q, off_wait_q;
  logic [7:0] step_time_q;

  // control state
  logic [2:0]                   op_q, op_d;
  logic [1:0]                   pending_q, pending_d;
  logic [7:0]                   steps_q, steps_d;
  logic                         operating_q, operating_d;
  logic                         backing_q, backing_d;
  logic                         performed_q, performed_d;
  logic                         self_op_q, self_op_d;
  logic [tacc_pkg::MoveW-1:0]   move_q, move_d;
  logic [tacc_pkg::SettleW-1:0] settle_q, settle_d;
  logic [1:0]                   pins_q, pins_d;

  // per-beat scratch and arithmetic
  logic [2:0]                   note_q, note_d;
  logic [1:0]                   status_q, status_d;
  logic                         query_q, query_d;
  logic                         hit_q, hit_d;
  logic [15:0]                  prod_q, prod_d;
  logic [tacc_pkg::SettleW-1:0] thr_q, thr_d;
  logic [tacc_pkg::MoveW-1:0]   limit_q, limit_d;
  tacc_pkg::result_t            res_q, res_d;

  logic stop_fire;
  logic resp_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_wait_q <= tacc_pkg::SettleWaitRst;
      off_wait_q    <= tacc_pkg::OffWaitRst;
      step_time_q   <= tacc_pkg::StepTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tacc_pkg::CFG_SETTLE_WAIT: settle_wait_q <= cfg_data_i;
        tacc_pkg::CFG_OFF_WAIT:    off_wait_q    <= cfg_data_i;
        tacc_pkg::CFG_STEP_TIME:   step_time_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic       do_start;
    logic       at_limit;
    logic [2:0] start_op;
    logic       over;

    op_d        = op_q;
    pending_d   = pending_q;
    steps_d     = steps_q;
    operating_d = operating_q;
    backing_d   = backing_q;
    performed_d = performed_q;
    self_op_d   = self_op_q;
    move_d      = move_q;
    settle_d    = settle_q;
    pins_d      = pins_q;
    note_d      = note_q;
    status_d    = status_q;
    query_d     = query_q;
    hit_d       = hit_q;
    prod_d      = prod_q;
    thr_d       = thr_q;
    limit_d     = limit_q;
    res_d       = res_q;
    stop_fire   = 1'b0;
    resp_fire   = 1'b0;
    do_start    = 1'b0;
    at_limit    = 1'b0;
    start_op    = tacc_pkg::OP_NONE;
    over        = 1'b0;

    if (cmd_i.exec) begin
      note_d   = tacc_pkg::NOTE_NONE;
      status_d = tacc_pkg::ST_NONE;
      query_d  = 1'b0;
      hit_d    = 1'b0;
      unique case (item_i.req_type)
        tacc_pkg::REQ_TICK: begin
          if (move_q != '1) move_d = move_q + 1'b1;
          if (settle_q != '1) settle_d = settle_q + 1'b1;
        end
        tacc_pkg::REQ_TRIGGER: begin
          if (item_i.action <= tacc_pkg::ACT_OFF) begin
            pending_d = item_i.action + 2'd1;
            if (item_i.action != tacc_pkg::ACT_OFF) steps_d = item_i.step_count;
            query_d = 1'b1;
          end
        end
        tacc_pkg::REQ_REPORT: begin
          unique case (pending_q)
            tacc_pkg::PEND_INC: begin
              do_start = 1'b1;
              start_op = tacc_pkg::OP_INC;
              at_limit = (item_i.position_code == tacc_pkg::POS_HIGH);
            end
            tacc_pkg::PEND_DEC: begin
              do_start = 1'b1;
              start_op = tacc_pkg::OP_DEC;
              at_limit = (item_i.position_code == tacc_pkg::POS_LOW);
            end
            tacc_pkg::PEND_OFF: begin
              do_start = 1'b1;
              start_op = tacc_pkg::OP_OFF;
              at_limit = (item_i.position_code == tacc_pkg::POS_LOW);
            end
            default: ;
          endcase
          if (do_start) begin
            if (at_limit || operating_q || self_op_q) begin
              status_d = tacc_pkg::ST_REJECT;
            end else begin
              op_d = start_op;
              if (start_op == tacc_pkg::OP_INC) begin
                pins_d = tacc_pkg::PINS_SLOW;
                note_d = tacc_pkg::NOTE_MOVING;
              end else begin
                pins_d = tacc_pkg::PINS_FAST;
                note_d = (start_op == tacc_pkg::OP_OFF) ? tacc_pkg::NOTE_SWITCHING
                                                          : tacc_pkg::NOTE_MOVING;
              end
              if (start_op != tacc_pkg::OP_OFF) move_d = '0;
              operating_d = 1'b1;
              status_d    = tacc_pkg::ST_ACCEPT;
            end
          end
        end
        tacc_pkg::REQ_LIMIT: begin
          if (backing_q) begin
            hit_d = (op_q == tacc_pkg::OP_BACK) &&
                    (item_i.event_code == tacc_pkg::EVT_PREV ||
                     item_i.event_code == tacc_pkg::EVT_HIGH);
          end else if (operating_q) begin
            hit_d = (item_i.event_code == tacc_pkg::EVT_HIGH && op_q == tacc_pkg::OP_INC) ||
                    (item_i.event_code == tacc_pkg::EVT_LOW &&
                     (op_q == tacc_pkg::OP_DEC || op_q == tacc_pkg::OP_OFF));
          end
        end
        tacc_pkg::REQ_BACKOFF: begin
          performed_d = 1'b0;
          op_d        = tacc_pkg::OP_BACK;
          note_d      = tacc_pkg::NOTE_BACKING;
          pins_d      = tacc_pkg::PINS_SLOW;
          backing_d   = 1'b1;
        end
        tacc_pkg::REQ_SELF: begin
          self_op_d   = item_i.self_flag;
          pins_d      = tacc_pkg::PINS_HOLD;
          note_d      = tacc_pkg::NOTE_STOPPED;
          operating_d = 1'b0;
          settle_d    = '0;
          performed_d = 1'b1;
        end
        default: ;
      endcase
    end

    // the off wait is chosen only while the op is a switch-off; a back-off replaces any op, a switch-off too
    if (cmd_i.mul) begin
      prod_d = 16'(step_time_q) * 16'(steps_q);
      thr_d  = ((op_q == tacc_pkg::OP_OFF) ? 17'(off_wait_q) : 17'(settle_wait_q)) *
               17'(tacc_pkg::MsPerUnit);
    end

    if (cmd_i.lim) begin
      limit_d = 23'(prod_q) * 23'(tacc_pkg::MsPerUnit);
    end

    if (cmd_i.load) begin
      over      = operating_q && (op_q != tacc_pkg::OP_OFF) && (move_q >= limit_q);
      stop_fire = over || hit_q;
      if (stop_fire) begin
        pins_d = tacc_pkg::PINS_HOLD;
        note_d = tacc_pkg::NOTE_STOPPED;
        if (backing_q) begin
          op_d      = tacc_pkg::OP_NONE;
          backing_d = 1'b0;
        end else begin
          operating_d = 1'b0;
          settle_d    = '0;
          performed_d = 1'b1;
        end
      end

      res_d.completion = tacc_pkg::CMP_NONE;
      resp_fire = performed_d && (settle_d >= thr_q);
      if (resp_fire) begin
        unique case (op_d)
          tacc_pkg::OP_INC: res_d.completion = tacc_pkg::CMP_INC;
          tacc_pkg::OP_DEC: res_d.completion = tacc_pkg::CMP_DEC;
          tacc_pkg::OP_OFF: res_d.completion = tacc_pkg::CMP_OFF;
          default: res_d.completion = tacc_pkg::CMP_NONE;
        endcase
        performed_d = 1'b0;
      end

      if (operating_d) begin
        res_d.operation_now = (op_d <= tacc_pkg::OP_BACK) ? op_d : tacc_pkg::OP_NONE;
      end else if (backing_d) begin
        res_d.operation_now = tacc_pkg::OP_BACK;
      end else begin
        res_d.operation_now = tacc_pkg::OP_NONE;
      end

      res_d.slow_pin       = pins_d[0];
      res_d.fast_pin       = pins_d[1];
      res_d.notice         = note_d;
      res_d.motor_active   = (pins_d == tacc_pkg::PINS_SLOW) || (pins_d == tacc_pkg::PINS_FAST);
      res_d.command_status = status_q;
      res_d.query_request  = query_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= tacc_pkg::OP_NONE;
      pending_q   <= tacc_pkg::PEND_NONE;
      steps_q     <= '0;
      operating_q <= 1'b0;
      backing_q   <= 1'b0;
      performed_q <= 1'b0;
      self_op_q   <= 1'b0;
      move_q      <= '0;
      settle_q    <= '0;
      pins_q      <= tacc_pkg::PINS_IDLE;
    end else begin
      op_q        <= op_d;
      pending_q   <= pending_d;
      steps_q     <= steps_d;
      operating_q <= operating_d;
      backing_q   <= backing_d;
      performed_q <= performed_d;
      self_op_q   <= self_op_d;
      move_q      <= move_d;
      settle_q    <= settle_d;
      pins_q      <= pins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q   <= note_d;
    status_q <= status_d;
    query_q  <= query_d;
    hit_q    <= hit_d;
    prod_q   <= prod_d;
    thr_q    <= thr_d;
    limit_q  <= limit_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

`ifndef NO_ASSERTIONS
  a_driven_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pins_q == tacc_pkg::PINS_SLOW || pins_q == tacc_pkg::PINS_FAST) |->
      (operating_q || backing_q))
    else $error("actuator driven with no move or back-off running");

  a_resp_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && resp_fire) |=> !performed_q)
    else $error("completion left the response pending");

  a_stop_restarts_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && stop_fire && !backing_q) |=> (settle_q == '0 && !operating_q))
    else $error("move stop did not restart the settle timer");
`endif

endmodule

[rtl/timed_actuator_command_controller.sv]
// a result beat is registered after the sequencer walks the step product, the scaling to
//   milliseconds and the check stage; a new item is taken only once the result is loaded,
//   and a stalled output holds the check stage
// configuration beats are taken every cycle and act at once
// reset (rst_ni low, asynchronous): registers to their documented defaults, no move,
//   both pins low, timers and flags cleared, no result pending
module timed_actuator_command_controller (
  input logic         clk_i,
  input logic         rst_ni,
  tacc_in_if.sink     in_i,
  tacc_out_if.source  out_o,
  tacc_cfg_if.sink    cfg_i
);

  tacc_pkg::cmd_t    cmd;
  tacc_pkg::item_t   item;
  tacc_pkg::result_t res;
  logic              in_ready;
  logic              out_valid;

  // configuration writes never stall
  assign cfg_i.ready = 1'b1;

  // pack the input beat for the datapath
  assign item.req_type      = in_i.req_type;
  assign item.action        = in_i.action;
  assign item.step_count    = in_i.step_count;
  assign item.position_code = in_i.position_code;
  assign item.event_code    = in_i.event_code;
  assign item.self_flag     = in_i.self_flag;

  assign in_i.ready = in_ready;

  // sequencer: one item at a time, output register decouples the sink
  tacc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // state, timers, move limit arithmetic and result register
  tacc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .item_i     (item),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.reg_idx),
    .cfg_data_i (cfg_i.wdata),
    .res_o      (res)
  );

  // result beat
  assign out_o.valid          = out_valid;
  assign out_o.slow_pin       = res.slow_pin;
  assign out_o.fast_pin       = res.fast_pin;
  assign out_o.notice         = res.notice;
  assign out_o.motor_active   = res.motor_active;
  assign out_o.command_status = res.command_status;
  assign out_o.query_request  = res.query_request;
  assign out_o.completion     = res.completion;
  assign out_o.operation_now  = res.operation_now;

endmodule
